FILE: rtl/cinv_pkg.sv
// ----------------------------------------------------------------------------
// cinv_pkg
// Shared widths, chord interval table and note role codes for the chord
// inversion voicing block.
// ----------------------------------------------------------------------------
package cinv_pkg;

  // fixed field widths
  localparam int AMOUNT_W   = 16;
  localparam int SEL_W      = 5;
  localparam int RATIO_W    = 22;
  localparam int LEVEL_W    = 15;
  localparam int UP_W       = 14;
  localparam int BASE_W     = 18;
  localparam int OUT_VOICES = 5;
  localparam int ROM_ROWS   = 17;
  localparam int ROM_NOTES  = 4;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 15'd16384;
  localparam logic [RATIO_W-1:0] RATIO_MAX  = 22'h3FFFFF;

  // role of a note in the current layout
  typedef enum logic [2:0] {
    ROLE_SHARED = 3'b001,  // note split over two voices, crossfaded
    ROLE_LOW    = 3'b010,  // note sits on the lower voice of its pair
    ROLE_HIGH   = 3'b100   // note sits on the upper voice of its pair
  } note_role_t;

  // interval ratios, 2^(semitones/12) in unsigned Q2.16
  localparam logic [BASE_W-1:0] CHORD_ROM [ROM_ROWS][ROM_NOTES] = '{
    '{18'd65536, 18'd65574, 18'd130996, 18'd131072},
    '{18'd65536, 18'd98193, 18'd98250,  18'd131072},
    '{18'd65536, 18'd77936, 18'd98193,  18'd131072},
    '{18'd65536, 18'd77936, 18'd98193,  18'd116772},
    '{18'd65536, 18'd77936, 18'd116772, 18'd147123},
    '{18'd65536, 18'd77936, 18'd116772, 18'd174960},
    '{18'd65536, 18'd82570, 18'd98193,  18'd131072},
    '{18'd65536, 18'd82570, 18'd98193,  18'd123715},
    '{18'd65536, 18'd82570, 18'd123715, 18'd147123},
    '{18'd65536, 18'd87480, 18'd98193,  18'd131072},
    '{18'd65536, 18'd73562, 18'd110218, 18'd165140},
    '{18'd65536, 18'd82570, 18'd98193,  18'd110218},
    '{18'd65536, 18'd98193, 18'd165140, 18'd247431},
    '{18'd65536, 18'd82570, 18'd98193,  18'd116772},
    '{18'd65536, 18'd98193, 18'd116772, 18'd138866},
    '{18'd65536, 18'd77936, 18'd92682,  18'd116772},
    '{18'd65536, 18'd77936, 18'd92682,  18'd110218}
  };

endpackage

FILE: rtl/cinv_note_scale.sv
// ----------------------------------------------------------------------------
// cinv_note_scale
// Octave shift of one chord note: base ratio times 0.25 times 2^shift,
// rounded half up and saturated, plus the saturated double of that value.
// ----------------------------------------------------------------------------
module cinv_note_scale
  import cinv_pkg::*;
#(
  parameter int MAX_SHIFT = 5,
  parameter int KW        = 3
) (
  input  logic [BASE_W-1:0]  base,
  input  logic [KW-1:0]      shift,
  output logic [RATIO_W-1:0] ratio,
  output logic [RATIO_W-1:0] ratio_dbl
);

  localparam int SUM_W = BASE_W + MAX_SHIFT + 1;

  logic [SUM_W-1:0] shifted;
  logic [SUM_W-3:0] quarter;

  // scale by 2^shift, add half an lsb of the quarter, drop two bits
  assign shifted = (SUM_W'(base) << shift) + SUM_W'(2);
  assign quarter = shifted[SUM_W-1:2];

  // saturate to the ratio range
  always_comb begin
    if (quarter > (SUM_W-2)'(RATIO_MAX)) begin
      ratio = RATIO_MAX;
    end else begin
      ratio = quarter[RATIO_W-1:0];
    end
  end

  // octave-up copy for the lower voice of a shared note
  always_comb begin
    if (ratio[RATIO_W-1]) begin
      ratio_dbl = RATIO_MAX;
    end else begin
      ratio_dbl = {ratio[RATIO_W-2:0], 1'b0};
    end
  end

endmodule

FILE: rtl/chord_inversion_voicing.sv
// ----------------------------------------------------------------------------
// chord_inversion_voicing
// Lays a four-note chord out over the voices from an inversion position:
// rotation, octave shifts and a crossfade of the shared note.
//
//   channel     direction  handshake            word
//   inversion   in         inversion_valid/stall inversion_amount
//   voice       out        voice_valid/stall    voiceN_ratio, voiceN_level,
//                                               root_mask
//   cfg         in         cfg_valid/ready      cfg_data (chord select)
//
// One word per cycle while the output word is not stalled; each word passes
// through four register stages (scale, layout, octave shift, voice map).
// The whole pipeline advances together and halts while the output word is
// stalled; inversion_stall follows voice_stall in that case only.
// Synchronous reset empties the pipeline and selects chord 0.
// cfg_ready is always high; chord select is sampled at the first stage.
// ----------------------------------------------------------------------------
module chord_inversion_voicing
  import cinv_pkg::*;
#(
  parameter int NOTES       = 4,
  parameter int VOICES      = 5,
  parameter int CHORD_COUNT = 17
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SEL_W-1:0]    cfg_data,
  // input words
  input  logic                inversion_valid,
  output logic                inversion_stall,
  input  logic [AMOUNT_W-1:0] inversion_amount,
  // output words
  output logic                voice_valid,
  input  logic                voice_stall,
  output logic [RATIO_W-1:0]  voice0_ratio,
  output logic [RATIO_W-1:0]  voice1_ratio,
  output logic [RATIO_W-1:0]  voice2_ratio,
  output logic [RATIO_W-1:0]  voice3_ratio,
  output logic [RATIO_W-1:0]  voice4_ratio,
  output logic [LEVEL_W-1:0]  voice0_level,
  output logic [LEVEL_W-1:0]  voice1_level,
  output logic [LEVEL_W-1:0]  voice2_level,
  output logic [LEVEL_W-1:0]  voice3_level,
  output logic [LEVEL_W-1:0]  voice4_level,
  output logic [4:0]          root_mask
);

  localparam int NV       = NOTES * VOICES;
  localparam int IP_W     = $clog2(NV);
  localparam int PROD_W   = AMOUNT_W + IP_W;
  localparam int VW       = $clog2(VOICES);
  localparam int RN_W     = $clog2(NOTES);
  localparam int KW       = $clog2(VOICES + 1);
  localparam int TW       = VW + 2;
  localparam int SEL_LAST = ((CHORD_COUNT < ROM_ROWS) ? CHORD_COUNT : ROM_ROWS) - 1;

  // integer part to rotation and shared note, worked out at elaboration
  function automatic logic [NV*VW-1:0] build_rot();
    logic [NV*VW-1:0] t;
    t = '0;
    for (int j = 0; j < NV; j++) begin
      t[j*VW +: VW] = VW'(j / NOTES);
    end
    return t;
  endfunction

  function automatic logic [NV*RN_W-1:0] build_rn();
    logic [NV*RN_W-1:0] t;
    t = '0;
    for (int j = 0; j < NV; j++) begin
      t[j*RN_W +: RN_W] = RN_W'(j % NOTES);
    end
    return t;
  endfunction

  localparam logic [NV*VW-1:0]   ROT_TAB = build_rot();
  localparam logic [NV*RN_W-1:0] RN_TAB  = build_rn();

  logic                 chord_select;
  logic [SEL_W-1:0]     chord_sel;
  logic                 adv;

  logic                 s1_valid;
  logic [PROD_W-1:0]    s1_prod;
  logic [SEL_W-1:0]     s1_sel;

  logic                 s2_valid;
  logic [BASE_W-1:0]    s2_base [NOTES];
  logic [KW-1:0]        s2_k    [NOTES];
  logic [VW-1:0]        s2_tgt  [NOTES];
  logic [VW-1:0]        s2_prv  [NOTES];
  note_role_t           s2_role [NOTES];
  logic [UP_W-1:0]      s2_up;
  logic                 s2_rn_zero;
  logic [NOTES-1:0]     s2_shared;

  logic                 s3_valid;
  logic [RATIO_W-1:0]   s3_ratio [NOTES];
  logic [RATIO_W-1:0]   s3_dbl   [NOTES];
  logic [VW-1:0]        s3_tgt   [NOTES];
  logic [VW-1:0]        s3_prv   [NOTES];
  note_role_t           s3_role  [NOTES];
  logic [UP_W-1:0]      s3_up;
  logic                 s3_rn_zero;

  logic [IP_W-1:0]      ip;
  logic [VW-1:0]        rot;
  logic [RN_W-1:0]      rn;
  logic [KW-1:0]        k_c    [NOTES];
  logic [VW-1:0]        tgt_c  [NOTES];
  logic [VW-1:0]        prv_c  [NOTES];
  note_role_t           role_c [NOTES];
  logic [RATIO_W-1:0]   sc_ratio [NOTES];
  logic [RATIO_W-1:0]   sc_dbl   [NOTES];

  logic [RATIO_W-1:0]   v_ratio [VOICES];
  logic [LEVEL_W-1:0]   v_level [VOICES];
  logic [VOICES-1:0]    v_mask;
  logic [4:0]           mask_out;

  logic [RATIO_W-1:0]   out_ratio [OUT_VOICES];
  logic [LEVEL_W-1:0]   out_level [OUT_VOICES];

  // chord select register
  logic [SEL_W-1:0] chord_reg;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chord_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      chord_reg <= cfg_data;
    end
  end

  assign chord_select = (chord_reg > SEL_W'(SEL_LAST));
  assign chord_sel    = chord_select ? SEL_W'(SEL_LAST) : chord_reg;

  // whole pipeline moves unless the output word is held
  assign adv             = !(voice_valid && voice_stall);
  assign inversion_stall = !adv;

  // stage 1: scale by notes times voices
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= inversion_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && inversion_valid) begin
      s1_prod <= PROD_W'(inversion_amount) * PROD_W'(NV);
      s1_sel  <= chord_sel;
    end
  end

  // stage 2: split, rotate, per-note layout and table fetch
  assign ip  = s1_prod[PROD_W-1:AMOUNT_W];
  assign rot = ROT_TAB[ip*VW +: VW];
  assign rn  = RN_TAB[ip*RN_W +: RN_W];

  for (genvar i = 0; i < NOTES; i++) begin : g_layout
    logic [TW-1:0] t0, t1, t2;
    // note i lands on voice (i + VOICES - rot) mod VOICES
    assign t0 = TW'(i) + TW'(VOICES) - TW'(rot);
    assign t1 = (t0 >= TW'(VOICES)) ? t0 - TW'(VOICES) : t0;
    assign t2 = (t1 >= TW'(VOICES)) ? t1 - TW'(VOICES) : t1;
    assign tgt_c[i] = t2[VW-1:0];
    assign prv_c[i] = (tgt_c[i] == '0) ? VW'(VOICES - 1) : tgt_c[i] - VW'(1);
    // notes below the shared one have gone up an extra octave
    assign k_c[i] = KW'(rot) + KW'(RN_W'(i) < rn);
    always_comb begin
      if (RN_W'(i) == rn) begin
        role_c[i] = ROLE_SHARED;
      end else if (RN_W'(i) < rn) begin
        role_c[i] = ROLE_LOW;
      end else begin
        role_c[i] = ROLE_HIGH;
      end
    end
    assign s2_shared[i] = (s2_role[i] == ROLE_SHARED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      for (int i = 0; i < NOTES; i++) begin
        s2_base[i] <= CHORD_ROM[s1_sel][2'(i)];
        s2_k[i]    <= k_c[i];
        s2_tgt[i]  <= tgt_c[i];
        s2_prv[i]  <= prv_c[i];
        s2_role[i] <= role_c[i];
      end
      s2_up      <= s1_prod[AMOUNT_W-1:2];
      s2_rn_zero <= (rn == '0);
    end
  end

  // stage 3: octave shift and rounding per note
  for (genvar i = 0; i < NOTES; i++) begin : g_scale
    cinv_note_scale #(
      .MAX_SHIFT (VOICES),
      .KW        (KW)
    ) u_scale (
      .base      (s2_base[i]),
      .shift     (s2_k[i]),
      .ratio     (sc_ratio[i]),
      .ratio_dbl (sc_dbl[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      for (int i = 0; i < NOTES; i++) begin
        s3_ratio[i] <= sc_ratio[i];
        s3_dbl[i]   <= sc_dbl[i];
        s3_tgt[i]   <= s2_tgt[i];
        s3_prv[i]   <= s2_prv[i];
        s3_role[i]  <= s2_role[i];
      end
      s3_up      <= s2_up;
      s3_rn_zero <= s2_rn_zero;
    end
  end

  // stage 4: map notes onto voices, higher-numbered note wins a clash
  always_comb begin
    for (int v = 0; v < VOICES; v++) begin
      v_ratio[v] = '0;
      v_level[v] = '0;
      for (int i = 0; i < NOTES; i++) begin
        case (s3_role[i])
          ROLE_SHARED: begin
            if (s3_tgt[i] == VW'(v)) begin
              v_ratio[v] = s3_ratio[i];
              v_level[v] = FULL_LEVEL - LEVEL_W'(s3_up);
            end
            if (s3_prv[i] == VW'(v)) begin
              v_ratio[v] = s3_dbl[i];
              v_level[v] = LEVEL_W'(s3_up);
            end
          end
          ROLE_LOW: begin
            if (s3_prv[i] == VW'(v)) begin
              v_ratio[v] = s3_ratio[i];
              v_level[v] = FULL_LEVEL;
            end
          end
          default: begin
            if (s3_tgt[i] == VW'(v)) begin
              v_ratio[v] = s3_ratio[i];
              v_level[v] = FULL_LEVEL;
            end
          end
        endcase
      end
    end
  end

  // root note voices: lower voice of note 0, and its upper one when shared
  always_comb begin
    v_mask = '0;
    v_mask[s3_prv[0]] = 1'b1;
    if (s3_rn_zero) begin
      v_mask[s3_tgt[0]] = 1'b1;
    end
  end

  if (VOICES >= OUT_VOICES) begin : g_mask_wide
    assign mask_out = v_mask[4:0];
  end else begin : g_mask_narrow
    assign mask_out = 5'(v_mask);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_valid <= 1'b0;
    end else if (adv) begin
      voice_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid) begin
      for (int v = 0; v < OUT_VOICES; v++) begin
        if (v < VOICES) begin
          out_ratio[v] <= v_ratio[v];
          out_level[v] <= v_level[v];
        end else begin
          out_ratio[v] <= '0;
          out_level[v] <= '0;
        end
      end
      root_mask <= mask_out;
    end
  end

  assign voice0_ratio = out_ratio[0];
  assign voice1_ratio = out_ratio[1];
  assign voice2_ratio = out_ratio[2];
  assign voice3_ratio = out_ratio[3];
  assign voice4_ratio = out_ratio[4];
  assign voice0_level = out_level[0];
  assign voice1_level = out_level[1];
  assign voice2_level = out_level[2];
  assign voice3_level = out_level[3];
  assign voice4_level = out_level[4];

  // exactly one note is split between two voices
  a_one_shared: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> $countones(s2_shared) == 1)
    else $error("shared note count is not one");

  // table row stays inside the chord table
  a_sel_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> s1_sel <= SEL_W'(SEL_LAST))
    else $error("chord row out of range");

  // no voice is louder than full level
  a_level_max: assert property (@(posedge clk) disable iff (rst)
    voice_valid |-> (voice0_level <= FULL_LEVEL) && (voice1_level <= FULL_LEVEL) &&
                    (voice2_level <= FULL_LEVEL) && (voice3_level <= FULL_LEVEL) &&
                    (voice4_level <= FULL_LEVEL))
    else $error("voice level above full");

  // the root always sits on some reported voice
  a_root_seen: assert property (@(posedge clk) disable iff (rst)
    (VOICES <= OUT_VOICES) && voice_valid |-> root_mask != '0)
    else $error("root mask empty");

endmodule
